>>> sv/wcp_pkg.sv
// package: widths, codes and item types of the cubic wavetable phasor
`default_nettype none

package wcp_pkg;

  localparam int SAMPLE_BITS          = 24;
  localparam int ADDR_BITS            = 12;
  localparam int PHASE_BITS           = 32;
  localparam int LEN_BITS             = 4;
  localparam int TABLE_DEPTH_LOG2_DEF = 12;
  localparam int FRACTION_BITS_DEF    = 16;
  localparam int LEN_MIN              = 2;

  localparam logic [LEN_BITS-1:0] LEN_RESET = 4'd12;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                          kind;
    logic [ADDR_BITS-1:0]          table_address;
    logic signed [SAMPLE_BITS-1:0] table_value;
    logic [PHASE_BITS-1:0]         phase;
  } wcp_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          saturated;
  } wcp_out_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] m1;
    logic signed [SAMPLE_BITS-1:0] z;
    logic signed [SAMPLE_BITS-1:0] p1;
    logic signed [SAMPLE_BITS-1:0] p2;
  } wcp_taps_t;

endpackage

`default_nettype wire

>>> sv/wavetable_cubic_phasor.sv
// top level: banked wavetable, neighbor fetch and cubic interpolation pipeline
`default_nettype none

// Wavetable oscillator lookup with 4-point cubic interpolation. One item is
// accepted in every clock cycle and busy never rises; a lookup result appears
// on result_o with done_o high for one cycle once the item has passed the
// memory read stage, the coefficient stage and three multiply-then-add pairs,
// and a table write gives no result. The table is split into four banks by
// the low two index bits, each with one read port, so the four neighbors are
// fetched in the same cycle; a write is seen by a lookup taken in the very
// next cycle. The receiver cannot stall, so results must be taken as they
// come.
module wavetable_cubic_phasor
  import wcp_pkg::*;
#(
  parameter int TABLE_DEPTH_LOG2 = TABLE_DEPTH_LOG2_DEF,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire wcp_in_t             item_i,
  output logic                     done_o,
  output wcp_out_t                 result_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [LEN_BITS-1:0] cfg_data_i
);

  localparam int DL      = TABLE_DEPTH_LOG2;
  localparam int F       = FRACTION_BITS;
  localparam int BA      = (DL > 2) ? DL - 2 : 1;
  localparam int LATENCY = 8;

  logic [LEN_BITS-1:0] len_q;
  logic                accept, wr_en, rd_en;
  logic [4:0]          len_ext, len_eff;
  logic [5:0]          sh;
  logic [DL-1:0]       msk, idx, wr_idx;
  logic [PHASE_BITS+F-1:0] ext;
  logic [F-1:0]        frac_d, frac_q;
  logic [1:0]          idx_lo_q;
  logic                va_q;
  logic [SAMPLE_BITS-1:0] rd_data [4];
  logic [1:0]          sel_m1, sel_p1, sel_p2;
  wcp_taps_t           taps;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign wr_en       = accept && (item_i.kind == KIND_WRITE);
  assign rd_en       = accept && (item_i.kind == KIND_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_data_i;
    end
  end

  always_comb begin
    len_ext = {1'b0, len_q};
    if (len_ext < 5'(LEN_MIN)) begin
      len_eff = 5'(LEN_MIN);
    end else if (len_ext > 5'(DL)) begin
      len_eff = 5'(DL);
    end else begin
      len_eff = len_ext;
    end
    sh     = 6'(PHASE_BITS) - {1'b0, len_eff};
    msk    = ~({DL{1'b1}} << len_eff);
    idx    = DL'(item_i.phase >> sh);
    ext    = {item_i.phase, {F{1'b0}}};
    frac_d = F'(ext >> sh);
    wr_idx = DL'(item_i.table_address);
  end

  // four banks, bank b holds the entries whose index ends in b
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [SAMPLE_BITS-1:0] bank_q [2**BA];
    logic [SAMPLE_BITS-1:0] rdata_q;
    logic [1:0]             k;
    logic [DL-1:0]          addr_full;
    logic [BA-1:0]          ra, wa;
    logic                   we;

    assign k         = 2'(b) - idx[1:0] + 2'd1;
    assign addr_full = (idx + DL'(k) - DL'(1)) & msk;
    assign ra        = BA'(addr_full >> 2);
    assign wa        = BA'(wr_idx >> 2);
    assign we        = wr_en && (wr_idx[1:0] == 2'(b));

    always_ff @(posedge clk_i) begin
      if (we) begin
        bank_q[wa] <= item_i.table_value;
      end
      if (rd_en) begin
        rdata_q <= bank_q[ra];
      end
    end

    assign rd_data[b] = rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_lo_q <= idx[1:0];
    frac_q   <= frac_d;
  end

  // rotate bank outputs back into neighbor order
  always_comb begin
    sel_m1  = idx_lo_q - 2'd1;
    sel_p1  = idx_lo_q + 2'd1;
    sel_p2  = idx_lo_q + 2'd2;
    taps.m1 = $signed(rd_data[sel_m1]);
    taps.z  = $signed(rd_data[idx_lo_q]);
    taps.p1 = $signed(rd_data[sel_p1]);
    taps.p2 = $signed(rd_data[sel_p2]);
  end

  wcp_interp #(
    .FRACTION_BITS(F)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q),
    .taps_i  (taps),
    .frac_i  (frac_q),
    .valid_o (done_o),
    .result_o(result_o)
  );

  a_done_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && item_i.kind == KIND_LOOKUP, LATENCY))
    else $error("result without a matching lookup item");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && item_i.kind == KIND_WRITE, LATENCY) |-> !done_o)
    else $error("table write produced a result");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.saturated) |->
      (result_o.sample == SAMPLE_MAX || result_o.sample == SAMPLE_MIN))
    else $error("saturated flag with a sample inside range");

endmodule

`default_nettype wire

>>> sv/wcp_interp.sv
// seven-stage fixed-point 4-point cubic interpolation pipeline
`default_nettype none

module wcp_interp
  import wcp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire wcp_taps_t                taps_i,
  input  wire logic [FRACTION_BITS-1:0] frac_i,
  output logic                          valid_o,
  output wcp_out_t                      result_o
);

  localparam int F   = FRACTION_BITS;
  localparam int CW  = SAMPLE_BITS + 4;
  localparam int HW  = SAMPLE_BITS + 5;
  localparam int FW  = F + 1;
  localparam int PW1 = CW + FW;
  localparam int PW2 = HW + FW;
  localparam int SW1 = PW1 + 1;
  localparam int SW2 = PW2 + 1;
  localparam int YW  = SW2 - F - 1;

  // coefficients
  logic signed [CW-1:0] m1e, ze, p1e, p2e, dz;
  logic signed [CW-1:0] c1_d, c2_d, c3_d;

  always_comb begin
    m1e  = CW'(taps_i.m1);
    ze   = CW'(taps_i.z);
    p1e  = CW'(taps_i.p1);
    p2e  = CW'(taps_i.p2);
    dz   = ze - p1e;
    c1_d = p1e - m1e;
    c2_d = (p1e <<< 2) + (m1e <<< 1) - (ze <<< 2) - ze - p2e;
    c3_d = (dz <<< 1) + dz - m1e + p2e;
  end

  logic                          v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vo_q;
  logic signed [CW-1:0]          c1_1_q, c2_1_q, c3_1_q, c1_2_q, c2_2_q, c1_3_q, c1_4_q;
  logic signed [SAMPLE_BITS-1:0] z1_q, z2_q, z3_q, z4_q, z5_q, z6_q;
  logic [F-1:0]                  f1_q, f2_q, f3_q, f4_q, f5_q;
  logic signed [PW1-1:0]         pr1_q;
  logic signed [PW2-1:0]         pr2_q, pr3_q;
  logic signed [HW-1:0]          h_q, g_q;
  wcp_out_t                      res_q;

  logic signed [FW-1:0]  fs1, fs3, fs5;
  logic signed [SW1-1:0] hsum;
  logic signed [SW2-1:0] gsum, ysum, yrnd, yadj;
  logic signed [YW-1:0]  yw;
  wcp_out_t              res_d;

  always_comb begin
    fs1  = $signed({1'b0, f1_q});
    fs3  = $signed({1'b0, f3_q});
    fs5  = $signed({1'b0, f5_q});
    hsum = (SW1'(c2_2_q) <<< F) + SW1'(pr1_q);
    gsum = (SW2'(c1_4_q) <<< F) + SW2'(pr2_q);
    ysum = (SW2'(z6_q) <<< (F + 1)) + SW2'(pr3_q);
    // round toward zero for negative sums
    yrnd = ysum[SW2-1] ? $signed({{(SW2-F-1){1'b0}}, {(F+1){1'b1}}}) : '0;
    yadj = ysum + yrnd;
    yw   = YW'(yadj >>> (F + 1));
    if (yw > YW'(SAMPLE_MAX)) begin
      res_d.sample    = SAMPLE_MAX;
      res_d.saturated = 1'b1;
    end else if (yw < YW'(SAMPLE_MIN)) begin
      res_d.sample    = SAMPLE_MIN;
      res_d.saturated = 1'b1;
    end else begin
      res_d.sample    = SAMPLE_BITS'(yw);
      res_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    c1_1_q <= c1_d;
    c2_1_q <= c2_d;
    c3_1_q <= c3_d;
    z1_q   <= taps_i.z;
    f1_q   <= frac_i;
    // stage 2
    pr1_q  <= PW1'(c3_1_q) * PW1'(fs1);
    c1_2_q <= c1_1_q;
    c2_2_q <= c2_1_q;
    z2_q   <= z1_q;
    f2_q   <= f1_q;
    // stage 3
    h_q    <= HW'(hsum >>> F);
    c1_3_q <= c1_2_q;
    z3_q   <= z2_q;
    f3_q   <= f2_q;
    // stage 4
    pr2_q  <= PW2'(h_q) * PW2'(fs3);
    c1_4_q <= c1_3_q;
    z4_q   <= z3_q;
    f4_q   <= f3_q;
    // stage 5
    g_q    <= HW'(gsum >>> F);
    z5_q   <= z4_q;
    f5_q   <= f4_q;
    // stage 6
    pr3_q  <= PW2'(g_q) * PW2'(fs5);
    z6_q   <= z5_q;
    // stage 7
    res_q  <= res_d;
  end

  assign valid_o  = vo_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

>>> tb/wavetable_cubic_phasor_test.sv
// testbench: random table loads and phase lookups checked against a cubic wavetable model
module wavetable_cubic_phasor_test;
  import wcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESULT_LATENCY = 8;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int ITEMS_PER_LEN  = 89;
  localparam int NUM_LENGTHS    = 16;
  localparam int FB             = FRACTION_BITS_DEF;
  localparam int TABLE_SIZE     = 1 << TABLE_DEPTH_LOG2_DEF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  wcp_in_t             item = '0;
  logic                done_o;
  wcp_out_t            result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LEN_BITS-1:0] cfg_data_i = '0;

  wavetable_cubic_phasor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // table lengths stepped through after the reset setting, all register codes
  logic [LEN_BITS-1:0] length_plan [NUM_LENGTHS] = '{
    4'd0, 4'd15, 4'd2, 4'd1, 4'd13, 4'd3, 4'd12, 4'd5,
    4'd8, 4'd4, 4'd10, 4'd14, 4'd7, 4'd11, 4'd6, 4'd9
  };

  wcp_in_t                       queued_items [$];
  wcp_out_t                      expected_samples [$];
  logic signed [SAMPLE_BITS-1:0] wave_table [TABLE_SIZE];
  logic [LEN_BITS-1:0]           length_reg = LEN_RESET;
  bit                            loaded [TABLE_SIZE];
  int unsigned                   gen_len = TABLE_DEPTH_LOG2_DEF;
  int                            items_queued = 0;
  int                            mismatches = 0;
  int                            cycles = 0;
  int                            burst_left = 0;
  int                            gap_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned active_len(input logic [LEN_BITS-1:0] code);
    if (code < LEN_MIN) return LEN_MIN;
    if (code > TABLE_DEPTH_LOG2_DEF) return TABLE_DEPTH_LOG2_DEF;
    return code;
  endfunction

  function automatic wcp_out_t cubic_sample(input logic [PHASE_BITS-1:0] phase);
    int unsigned            len;
    logic [ADDR_BITS-1:0]   msk;
    logic [ADDR_BITS-1:0]   idx;
    logic [PHASE_BITS-1:0]  shifted;
    longint                 frac, m1, z, p1, p2, c1, c2, c3, h, g, acc, y;
    wcp_out_t               res;
    len     = active_len(length_reg);
    msk     = ADDR_BITS'((1 << len) - 1);
    idx     = ADDR_BITS'(phase >> (PHASE_BITS - len));
    shifted = phase << len;
    frac    = longint'(shifted[PHASE_BITS-1 -: FB]);
    m1 = wave_table[(idx - 1'b1) & msk];
    z  = wave_table[idx & msk];
    p1 = wave_table[(idx + 1'b1) & msk];
    p2 = wave_table[(idx + 2'd2) & msk];
    c1 = p1 - m1;
    c2 = 4 * p1 + 2 * m1 - 5 * z - p2;
    c3 = 3 * (z - p1) - m1 + p2;
    h   = ((c2 <<< FB) + c3 * frac) >>> FB;
    g   = ((c1 <<< FB) + h * frac) >>> FB;
    acc = (z <<< (FB + 1)) + g * frac;
    y   = (acc < 0) ? -((-acc) >>> (FB + 1)) : (acc >>> (FB + 1));
    res.saturated = 1'b0;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      res.saturated = 1'b1;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      res.saturated = 1'b1;
    end
    res.sample = y[SAMPLE_BITS-1:0];
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [PHASE_BITS-1:0] random_phase();
    logic [PHASE_BITS-1:0] ph;
    logic [PHASE_BITS-1:0] low;
    ph  = $urandom();
    low = {PHASE_BITS{1'b1}} >> gen_len;
    case ($urandom_range(0, 9))
      0: return ph & ~low;
      1: return ph | low;
      default: return ph;
    endcase
  endfunction

  task automatic queue_write(input logic [ADDR_BITS-1:0] addr,
                             input logic signed [SAMPLE_BITS-1:0] value);
    wcp_in_t it;
    it.kind          = KIND_WRITE;
    it.table_address = addr;
    it.table_value   = value;
    it.phase         = $urandom();
    queued_items.push_back(it);
    loaded[addr] = 1'b1;
    items_queued++;
  endtask

  // loads any neighbor not yet written before the lookup itself
  task automatic queue_lookup(input logic [PHASE_BITS-1:0] phase);
    wcp_in_t              it;
    logic [ADDR_BITS-1:0] msk;
    logic [ADDR_BITS-1:0] idx;
    logic [ADDR_BITS-1:0] addr;
    msk = ADDR_BITS'((1 << gen_len) - 1);
    idx = ADDR_BITS'(phase >> (PHASE_BITS - gen_len));
    for (int k = -1; k <= 2; k++) begin
      addr = ADDR_BITS'(idx + k) & msk;
      if (!loaded[addr]) queue_write(addr, random_value());
    end
    it.kind          = KIND_LOOKUP;
    it.table_address = ADDR_BITS'($urandom());
    it.table_value   = SAMPLE_BITS'($urandom());
    it.phase         = phase;
    queued_items.push_back(it);
    items_queued++;
  endtask

  // four neighbors at opposite rails so the curve overshoots
  task automatic queue_clip_case();
    logic [PHASE_BITS-1:0]         ph;
    logic [ADDR_BITS-1:0]          msk;
    logic [ADDR_BITS-1:0]          idx;
    logic signed [SAMPLE_BITS-1:0] rail;
    ph   = $urandom();
    msk  = ADDR_BITS'((1 << gen_len) - 1);
    idx  = ADDR_BITS'(ph >> (PHASE_BITS - gen_len));
    rail = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    queue_write((idx - 1'b1) & msk, ~rail);
    queue_write(idx & msk, rail);
    queue_write((idx + 1'b1) & msk, rail);
    queue_write((idx + 2'd2) & msk, ~rail);
    queue_lookup(ph);
  endtask

  task automatic queue_random_items(input int count);
    int target;
    int pick;
    target = items_queued + count;
    while (items_queued < target) begin
      pick = $urandom_range(0, 15);
      if (pick < 4) queue_write(ADDR_BITS'($urandom_range(0, TABLE_SIZE - 1)), random_value());
      else if (pick == 4) queue_clip_case();
      else queue_lookup(random_phase());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_items.size() != 0 || start || expected_samples.size() != 0);
    repeat (RESULT_LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_BITS-1:0] code);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    length_reg = code;
    gen_len    = active_len(code);
  endtask

  task automatic apply_item(input wcp_in_t it);
    if (it.kind == KIND_WRITE) wave_table[it.table_address] = it.table_value;
    else expected_samples.push_back(cubic_sample(it.phase));
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      item       <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) apply_item(item);
      if (!start || !busy) begin
        if (gap_left > 0 || queued_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          item  <= queued_items.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    wcp_out_t want;
    if (rst_ni && done_o) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sample %0d saturated %0b",
                   result_o.sample, result_o.saturated);
      end else begin
        want = expected_samples.pop_front();
        if (result_o.sample !== want.sample || result_o.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bad result: expected sample %0d saturated %0b, got sample %0d saturated %0b",
                     want.sample, want.saturated, result_o.sample, result_o.saturated);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("wavetable_cubic_phasor: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_write(ADDR_BITS'(TABLE_SIZE - 1), SAMPLE_MIN);
    queue_write(12'd0, SAMPLE_MAX);
    queue_write(12'd1, SAMPLE_MAX);
    queue_write(12'd2, SAMPLE_MIN);
    queue_lookup(32'h0008_0000);
    queue_write(12'd100, SAMPLE_MAX);
    queue_write(12'd101, SAMPLE_MIN);
    queue_write(12'd102, SAMPLE_MIN);
    queue_write(12'd103, SAMPLE_MAX);
    queue_lookup({12'd101, 20'h8_0000});
    queue_lookup(32'h0000_0000);
    queue_lookup(32'hFFFF_FFFF);
    queue_lookup(32'h000F_FFFF);
    queue_write(12'd1, '0);
    queue_lookup(32'h0004_0000);
    queue_lookup(32'h0010_0000);
    wait_drained();

    // each new length is written only once every earlier lookup has answered
    for (int i = 0; i < NUM_LENGTHS; i++) begin
      write_length(length_plan[i]);
      queue_random_items(ITEMS_PER_LEN);
      wait_drained();
    end

    if (expected_samples.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("wavetable_cubic_phasor: match");
    end else begin
      $display("wavetable_cubic_phasor: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/wcp_pkg.sv
sv/wcp_interp.sv
sv/wavetable_cubic_phasor.sv
tb/wavetable_cubic_phasor_test.sv
